>>> design/gns_pkg.sv
// Shared types and constants of the grid nearest-occupied search unit.
package gns_pkg;

  // Field widths of the stream words and the configuration registers.
  localparam int COORD_W    = 10;
  localparam int EXT_W      = 13;
  localparam int EV_W       = 16;
  localparam int LIM_W      = 7;
  localparam int DIST_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // Item kinds carried in the input tuser bit.
  typedef enum logic {
    KIND_ADD   = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_X = 2'd0,
    CFG_MAX_X = 2'd1,
    CFG_MIN_Y = 2'd2,
    CFG_MAX_Y = 2'd3
  } cfg_idx_e;

  // Reset values of the world bounds.
  localparam logic signed [COORD_W-1:0] MIN_X_RST = -10'sd10;
  localparam logic signed [COORD_W-1:0] MAX_X_RST = 10'sd10;
  localparam logic signed [COORD_W-1:0] MIN_Y_RST = -10'sd10;
  localparam logic signed [COORD_W-1:0] MAX_Y_RST = 10'sd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic take;
    logic check;
    logic scan;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic is_add;
    logic q_empty;
    logic scan_done;
    logic final_done;
  } stat_t;

endpackage

>>> design/gns_ctrl.sv
// Controller state machine of the grid nearest-occupied search unit.
module gns_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  input  gns_pkg::stat_t stat_i,
  output gns_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  // Commands follow the current state.
  always_comb begin
    cmd_o        = '0;
    cmd_o.clear  = (state_q == S_CLEAR);
    cmd_o.take   = ready_q & s_tvalid_i;
    cmd_o.check  = (state_q == S_CHECK);
    cmd_o.scan   = (state_q == S_SCAN);
    cmd_o.finish = (state_q == S_FINISH);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_o.take) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.is_add) state_d = S_IDLE;
        else if (stat_i.q_empty) state_d = S_FINISH;
        else state_d = S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.scan_done) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.final_done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and the registered ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == S_IDLE);
    end
  end

  assign s_tready_o = ready_q;

endmodule

>>> design/gns_dp.sv
// Datapath: bounds, cell memory, ring walker, probe pipeline and result registers.
module gns_dp #(
  parameter int GRID_W    = 64,
  parameter int GRID_H    = 64,
  parameter int MAX_LIMIT = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gns_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [gns_pkg::COORD_W-1:0]         cfg_data_i,
  input  logic                                s_tuser_i,
  input  logic [gns_pkg::IN_DATA_W-1:0]       s_tdata_i,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic [gns_pkg::OUT_DATA_W-1:0]      m_tdata_o,
  output logic                                m_tuser_o,
  output logic                                m_tlast_o,
  input  gns_pkg::cmd_t                       cmd_i,
  output gns_pkg::stat_t                      stat_o
);

  localparam int XW    = (GRID_W > 1) ? $clog2(GRID_W) : 1;
  localparam int YW    = (GRID_H > 1) ? $clog2(GRID_H) : 1;
  localparam int AW    = XW + YW;
  localparam int CELLS = 1 << AW;
  localparam int EW    = gns_pkg::EXT_W;
  localparam int CW    = gns_pkg::COORD_W;
  localparam int VW    = gns_pkg::EV_W;
  localparam int LW    = gns_pkg::LIM_W;
  localparam int DW    = gns_pkg::DIST_W;
  localparam logic signed [EW-1:0] SpanX = EW'(GRID_W - 1);
  localparam logic signed [EW-1:0] SpanY = EW'(GRID_H - 1);
  localparam logic [LW-1:0]        LimMax = LW'(MAX_LIMIT);

  typedef enum logic [1:0] {
    WALK_ORIGIN,
    WALK_AB,
    WALK_CD
  } walk_e;

  // Configuration registers.
  logic signed [CW-1:0] cmin_x_q, cmax_x_q, cmin_y_q, cmax_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmin_x_q <= gns_pkg::MIN_X_RST;
      cmax_x_q <= gns_pkg::MAX_X_RST;
      cmin_y_q <= gns_pkg::MIN_Y_RST;
      cmax_y_q <= gns_pkg::MAX_Y_RST;
    end else if (cfg_we_i) begin
      case (gns_pkg::cfg_idx_e'(cfg_idx_i))
        gns_pkg::CFG_MIN_X: cmin_x_q <= $signed(cfg_data_i);
        gns_pkg::CFG_MAX_X: cmax_x_q <= $signed(cfg_data_i);
        gns_pkg::CFG_MIN_Y: cmin_y_q <= $signed(cfg_data_i);
        gns_pkg::CFG_MAX_Y: cmax_y_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Effective bounds: the upper edge is clipped to the grid size.
  logic signed [EW-1:0] lx, hx, ly, hy, wx, wy, hx_e, hy_e;
  logic                 wok;

  always_comb begin
    lx   = EW'(cmin_x_q);
    hx   = EW'(cmax_x_q);
    ly   = EW'(cmin_y_q);
    hy   = EW'(cmax_y_q);
    wx   = hx - lx;
    wy   = hy - ly;
    hx_e = (wx > SpanX) ? lx + SpanX : hx;
    hy_e = (wy > SpanY) ? ly + SpanY : hy;
    wok  = !wx[EW-1] && !wy[EW-1];
  end

  // Incoming word fields; the limit saturates at MAX_LIMIT.
  logic [LW-1:0] lim_in, lim_sat;

  assign lim_in  = s_tdata_i[2*CW +: LW];
  assign lim_sat = (lim_in > LimMax) ? LimMax : lim_in;

  // Item registers, with the bounds captured when the word is taken.
  gns_pkg::kind_e       kind_q;
  logic signed [EW-1:0] x_q, y_q, elx_q, ehx_q, ely_q, ehy_q;
  logic                 wok_q;
  logic [LW-1:0]        lim_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      kind_q <= gns_pkg::kind_e'(s_tuser_i);
      x_q    <= EW'($signed(s_tdata_i[CW-1:0]));
      y_q    <= EW'($signed(s_tdata_i[CW +: CW]));
      elx_q  <= lx;
      ehx_q  <= hx_e;
      ely_q  <= ly;
      ehy_q  <= hy_e;
      wok_q  <= wok;
    end
  end

  // The limit is reset so that the count check holds from the first edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= '0;
    end else if (cmd_i.take) begin
      lim_q <= lim_sat;
    end
  end

  // Item check: world membership, cell address and farthest ring.
  logic signed [EW-1:0] dx, dy, rx, ry, mx, my, far_s;
  logic                 inb;
  logic [DW-1:0]        far_d;
  logic [AW-1:0]        add_addr;
  logic                 add_we;

  always_comb begin
    dx       = x_q - elx_q;
    dy       = y_q - ely_q;
    rx       = ehx_q - x_q;
    ry       = ehy_q - y_q;
    mx       = (dx > rx) ? dx : rx;
    my       = (dy > ry) ? dy : ry;
    far_s    = mx + my;
    far_d    = far_s[DW-1:0];
    inb      = wok_q && (x_q >= elx_q) && (x_q <= ehx_q) &&
               (y_q >= ely_q) && (y_q <= ehy_q);
    add_addr = {dx[XW-1:0], dy[YW-1:0]};
    add_we   = cmd_i.check && (kind_q == gns_pkg::KIND_ADD) && inb;
  end

  // Running event id.
  logic [VW-1:0] next_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_id_q <= '0;
    end else if (add_we) begin
      next_id_q <= next_id_q + 1'b1;
    end
  end

  // Clearing sweep address after reset.
  logic [AW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Ring walker registers.
  walk_e         ph_q;
  logic          sub_q, wend_q;
  logic [DW-1:0] d_q, i_q, far_q, dmi;

  // Probe pipeline and result holding registers.
  logic                 p_vld_q, pend_v_q, out_valid_q;
  logic signed [EW-1:0] px_q, py_q, pend_x_q, pend_y_q;
  logic [VW-1:0]        pend_ev_q;
  logic [LW-1:0]        cnt_q;
  logic                 hit, stall, take_hit, issue, out_free, load_mid, load_fin;

  // Probe coordinate for the walker position.
  logic signed [EW-1:0] ox, oy, px, py, pdx, pdy, dmi_s, i_s;
  logic                 probe_inb;
  logic [AW-1:0]        rd_addr;

  always_comb begin
    dmi   = d_q - i_q;
    dmi_s = $signed(EW'(dmi));
    i_s   = $signed(EW'(i_q));
    ox    = '0;
    oy    = '0;
    case (ph_q)
      WALK_ORIGIN: begin
        ox = '0;
        oy = '0;
      end
      WALK_AB: begin
        ox = sub_q ? dmi_s : -dmi_s;
        oy = sub_q ? i_s : -i_s;
      end
      WALK_CD: begin
        ox = sub_q ? dmi_s : -i_s;
        oy = sub_q ? -i_s : dmi_s;
      end
      default: begin
        ox = '0;
        oy = '0;
      end
    endcase
    px        = x_q + ox;
    py        = y_q + oy;
    pdx       = px - elx_q;
    pdy       = py - ely_q;
    rd_addr   = {pdx[XW-1:0], pdy[YW-1:0]};
    probe_inb = (px >= elx_q) && (px <= ehx_q) && (py >= ely_q) && (py <= ehy_q);
  end

  // Walker advance: origin, then each ring in its fixed edge order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= WALK_ORIGIN;
      sub_q  <= 1'b0;
      wend_q <= 1'b1;
      d_q    <= '0;
      i_q    <= '0;
      far_q  <= '0;
    end else if (cmd_i.check) begin
      ph_q   <= WALK_ORIGIN;
      sub_q  <= 1'b0;
      wend_q <= 1'b0;
      d_q    <= DW'(1);
      i_q    <= '0;
      far_q  <= far_d;
    end else if (issue) begin
      case (ph_q)
        WALK_ORIGIN: begin
          if (far_q == '0) begin
            wend_q <= 1'b1;
          end else begin
            ph_q <= WALK_AB;
            i_q  <= '0;
          end
        end
        WALK_AB: begin
          sub_q <= !sub_q;
          if (sub_q) begin
            if (i_q != d_q) begin
              i_q <= i_q + 1'b1;
            end else if (d_q != DW'(1)) begin
              ph_q <= WALK_CD;
              i_q  <= DW'(1);
            end else if (d_q == far_q) begin
              wend_q <= 1'b1;
            end else begin
              d_q <= d_q + 1'b1;
              i_q <= '0;
            end
          end
        end
        WALK_CD: begin
          sub_q <= !sub_q;
          if (sub_q) begin
            if (i_q != d_q - 1'b1) begin
              i_q <= i_q + 1'b1;
            end else if (d_q == far_q) begin
              wend_q <= 1'b1;
            end else begin
              ph_q <= WALK_AB;
              d_q  <= d_q + 1'b1;
              i_q  <= '0;
            end
          end
        end
        default: wend_q <= 1'b1;
      endcase
    end
  end

  // Cell memory: occupied flag above the event id.
  logic [VW:0] mem [CELLS];
  logic [VW:0] rdata_q;
  logic        rd_en;

  assign rd_en = cmd_i.scan && !stall;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem[clr_q] <= '0;
    end else if (add_we) begin
      mem[add_addr] <= {1'b1, next_id_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  // Hit detection and back-pressure from the result side.
  assign out_free = !out_valid_q || m_tready_i;
  assign hit      = cmd_i.scan && p_vld_q && rdata_q[VW] && (cnt_q < lim_q);
  assign stall    = hit && pend_v_q && !out_free;
  assign take_hit = hit && !stall;
  assign issue    = cmd_i.scan && !wend_q && (cnt_q < lim_q) && !stall;
  assign load_mid = take_hit && pend_v_q;
  assign load_fin = cmd_i.finish && out_free;

  // Probe stage alongside the memory read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (cmd_i.check) begin
      p_vld_q <= 1'b0;
    end else if (rd_en) begin
      p_vld_q <= issue && probe_inb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      px_q <= px;
      py_q <= py;
    end
  end

  // Hit count and the one pending hit that waits to learn if it is last.
  // Both start over when a word is taken, together with the new limit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
    end else if (cmd_i.take) begin
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
    end else if (take_hit) begin
      cnt_q    <= cnt_q + 1'b1;
      pend_v_q <= 1'b1;
    end else if (load_fin) begin
      pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_hit) begin
      pend_x_q  <= px_q;
      pend_y_q  <= py_q;
      pend_ev_q <= rdata_q[VW-1:0];
    end
  end

  // Output word register.
  logic          out_found_q, out_last_q;
  logic [CW-1:0] out_x_q, out_y_q;
  logic [VW-1:0] out_ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_mid || load_fin) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_mid) begin
      out_found_q <= 1'b1;
      out_x_q     <= pend_x_q[CW-1:0];
      out_y_q     <= pend_y_q[CW-1:0];
      out_ev_q    <= pend_ev_q;
      out_last_q  <= 1'b0;
    end else if (load_fin) begin
      out_found_q <= pend_v_q;
      out_x_q     <= pend_v_q ? pend_x_q[CW-1:0] : '0;
      out_y_q     <= pend_v_q ? pend_y_q[CW-1:0] : '0;
      out_ev_q    <= pend_v_q ? pend_ev_q : '0;
      out_last_q  <= 1'b1;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_found_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = {{(gns_pkg::OUT_DATA_W - 2*CW - VW){1'b0}}, out_ev_q, out_y_q, out_x_q};

  // Status back to the controller.
  always_comb begin
    stat_o            = '0;
    stat_o.clear_last = &clr_q;
    stat_o.is_add     = (kind_q == gns_pkg::KIND_ADD);
    stat_o.q_empty    = !inb || (lim_q == '0);
    stat_o.scan_done  = (wend_q || (cnt_q >= lim_q)) && !p_vld_q;
    stat_o.final_done = load_fin;
  end

  // The hit count never passes the limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= lim_q)
    else $error("hit count exceeds the query limit");

  // A probe in flight always lies inside the world.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_q |-> (px_q >= elx_q) && (px_q <= ehx_q) && (py_q >= ely_q) && (py_q <= ehy_q))
    else $error("probe outside the world bounds");

  // A finished walker issues no further probes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan && wend_q && !stall) |=> !p_vld_q)
    else $error("probe issued after the last ring");

  // The closing word of a query is marked last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fin |=> out_valid_q && out_last_q)
    else $error("final word of a query not marked last");

endmodule

>>> design/grid_nearest_occupied_search_unit.sv
// Top level of the grid nearest-occupied search unit.
// After reset the unit sweeps its cell memory clean, one cell per cycle, over
// 2**(clog2(GRID_W)+clog2(GRID_H)) cells (4096 at the default sizes); during that
// sweep it takes no input word, while configuration writes are accepted. An add
// word is accepted, then written to the memory. A query is accepted and checked,
// then visits the query cell and 4*d cells on each ring d out to the farthest world
// corner, drains the probe pipeline and sends the final word; the walk ends early
// once limit hits are found. The pace is set by the single read port of the cell
// memory, one probe per cycle; a stalled result port holds the walk.
module grid_nearest_occupied_search_unit #(
  parameter int GRID_W    = 64,
  parameter int GRID_H    = 64,
  parameter int MAX_LIMIT = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gns_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gns_pkg::COORD_W-1:0]        cfg_data_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // Fields from bit 0: pos_x[9:0], pos_y[19:10], limit[26:20], zero fill.
  input  logic [gns_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // Fields from bit 0: kind.
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // Fields from bit 0: hit_x[9:0], hit_y[19:10], event_num[35:20], zero fill.
  output logic [gns_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // Fields from bit 0: found.
  output logic                               m_axis_tuser_o,
  output logic                               m_axis_tlast_o
);

  gns_pkg::cmd_t  cmd;
  gns_pkg::stat_t stat;

  // Sequencing of clear, add, query walk and final word.
  gns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Bounds, memory, ring walker and result registers.
  gns_dp #(
    .GRID_W    (GRID_W),
    .GRID_H    (GRID_H),
    .MAX_LIMIT (MAX_LIMIT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tuser_i  (s_axis_tuser_i),
    .s_tdata_i  (s_axis_tdata_i),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule

>>> test/gns_checker.sv
// Checker that predicts and compares the result words of the grid nearest-occupied search unit.
module gns_checker import gns_pkg::*; #(
  parameter int GRID_W    = 64,
  parameter int GRID_H    = 64,
  parameter int MAX_LIMIT = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [COORD_W-1:0]    cfg_data_i,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  // Fields from bit 0: pos_x[9:0], pos_y[19:10], limit[26:20], zero fill.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // Fields from bit 0: kind.
  input  logic                  s_axis_tuser_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  // Fields from bit 0: hit_x[9:0], hit_y[19:10], event_num[35:20], zero fill.
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  // Fields from bit 0: found.
  input  logic                  m_axis_tuser_i,
  input  logic                  m_axis_tlast_i,
  output int                    mismatches_o,
  output int                    backlog_o,
  output int                    words_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = GRID_W * GRID_H;

  typedef struct packed {
    logic                      found;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic [EV_W-1:0]           event_num;
    logic                      last;
  } hit_word_t;

  // Shadow copy of the world bounds and the cell store.
  logic signed [COORD_W-1:0] bound_lo_x, bound_hi_x, bound_lo_y, bound_hi_y;
  bit                        cell_used [CELLS];
  logic [EV_W-1:0]           cell_event_id [CELLS];
  logic [EV_W-1:0]           event_ctr;

  // Words still to come from the block, oldest first, and the hits of the query in work.
  hit_word_t nearest_q[$];
  hit_word_t found_q[$];

  int box_lx, box_hx, box_ly, box_hy;
  int scan_cap;
  int mismatches;
  int words;

  // Effective world rectangle; a wide axis is clipped to the grid size.
  function automatic bit world_box();
    box_lx = bound_lo_x;
    box_hx = bound_hi_x;
    box_ly = bound_lo_y;
    box_hy = bound_hi_y;
    if (box_hx < box_lx || box_hy < box_ly) return 1'b0;
    if (box_hx - box_lx >= GRID_W) box_hx = box_lx + GRID_W - 1;
    if (box_hy - box_ly >= GRID_H) box_hy = box_ly + GRID_H - 1;
    return 1'b1;
  endfunction

  function automatic bit outside_box(int x, int y);
    return x < box_lx || x > box_hx || y < box_ly || y > box_hy;
  endfunction

  function automatic int span(int v);
    return (v < 0) ? -v : v;
  endfunction

  // An add inside the world stores the running event id; anything else is dropped.
  function automatic void mark_cell(int x, int y);
    int idx;
    if (!world_box() || outside_box(x, y)) return;
    idx = (x - box_lx) * GRID_H + (y - box_ly);
    cell_used[idx]     = 1'b1;
    cell_event_id[idx] = event_ctr;
    event_ctr          = event_ctr + 1'b1;
  endfunction

  // One cell of the walk: reported when inside the world, occupied, and below the cap.
  function automatic void probe_cell(int x, int y);
    int        idx;
    hit_word_t w;
    if (found_q.size() >= scan_cap || outside_box(x, y)) return;
    idx = (x - box_lx) * GRID_H + (y - box_ly);
    if (!cell_used[idx]) return;
    w.found     = 1'b1;
    w.hit_x     = x[COORD_W-1:0];
    w.hit_y     = y[COORD_W-1:0];
    w.event_num = cell_event_id[idx];
    w.last      = 1'b0;
    found_q     = {found_q, w};
  endfunction

  // Query cell first, then the Manhattan rings out to the farthest world corner.
  function automatic void search_rings(int x, int y, int lim);
    int        far, t, d, i;
    hit_word_t w;
    found_q.delete();
    if (world_box() && lim != 0 && !outside_box(x, y)) begin
      scan_cap = (lim > MAX_LIMIT) ? MAX_LIMIT : lim;
      probe_cell(x, y);
      far = span(x - box_lx) + span(y - box_ly);
      t = span(x - box_hx) + span(y - box_ly);
      if (t > far) far = t;
      t = span(x - box_lx) + span(y - box_hy);
      if (t > far) far = t;
      t = span(x - box_hx) + span(y - box_hy);
      if (t > far) far = t;
      for (d = 1; d <= far && found_q.size() < scan_cap; d++) begin
        for (i = 0; i <= d; i++) begin
          probe_cell(x - d + i, y - i);
          probe_cell(x + d - i, y + i);
        end
        for (i = 1; i < d; i++) begin
          probe_cell(x - i, y + d - i);
          probe_cell(x + d - i, y - i);
        end
      end
    end
    // Nothing to report gives a single empty word.
    if (found_q.size() == 0) begin
      w       = '0;
      found_q = {found_q, w};
    end
    found_q[found_q.size() - 1].last = 1'b1;
    nearest_q = {nearest_q, found_q};
  endfunction

  function automatic void compare_field(string what, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // Follow configuration writes, accepted input words and accepted result words.
  always @(posedge clk_i or negedge rst_ni) begin
    hit_word_t want;
    int        px, py, got_x, got_y;
    if (!rst_ni) begin
      bound_lo_x = MIN_X_RST;
      bound_hi_x = MAX_X_RST;
      bound_lo_y = MIN_Y_RST;
      bound_hi_y = MAX_Y_RST;
      foreach (cell_used[c]) cell_used[c] = 1'b0;
      event_ctr  = '0;
      nearest_q.delete();
      mismatches = 0;
      words      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MIN_X: bound_lo_x = cfg_data_i;
          CFG_MAX_X: bound_hi_x = cfg_data_i;
          CFG_MIN_Y: bound_lo_y = cfg_data_i;
          CFG_MAX_Y: bound_hi_y = cfg_data_i;
          default: ;
        endcase
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        px = $signed(s_axis_tdata_i[COORD_W-1:0]);
        py = $signed(s_axis_tdata_i[2*COORD_W-1:COORD_W]);
        if (kind_e'(s_axis_tuser_i) == KIND_ADD) begin
          mark_cell(px, py);
        end else begin
          search_rings(px, py, int'(s_axis_tdata_i[2*COORD_W+LIM_W-1:2*COORD_W]));
        end
      end

      if (m_axis_tvalid_i && m_axis_tready_i) begin
        words++;
        got_x = $signed(m_axis_tdata_i[COORD_W-1:0]);
        got_y = $signed(m_axis_tdata_i[2*COORD_W-1:COORD_W]);
        if (nearest_q.size() == 0) begin
          mismatches++;
          $display({"%0t: result word with nothing expected, actual found=%0b x=%0d y=%0d",
                    " event=%0d last=%0b"},
                   $time, m_axis_tuser_i, got_x, got_y,
                   m_axis_tdata_i[2*COORD_W+EV_W-1:2*COORD_W], m_axis_tlast_i);
        end else begin
          want = nearest_q.pop_front();
          compare_field("found", want.found, m_axis_tuser_i);
          compare_field("hit_x", want.hit_x, got_x);
          compare_field("hit_y", want.hit_y, got_y);
          compare_field("event_num", want.event_num,
                        m_axis_tdata_i[2*COORD_W+EV_W-1:2*COORD_W]);
          compare_field("last", want.last, m_axis_tlast_i);
        end
      end
    end
    mismatches_o <= mismatches;
    backlog_o    <= nearest_q.size();
    words_seen_o <= words;
  end

endmodule

>>> test/testbench.sv
// Top of the testbench: clock, reset, stimulus, and the final verdict for the search unit.
module testbench import gns_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_W    = 64;
  localparam int GRID_H    = 64;
  localparam int MAX_LIMIT = 64;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [COORD_W-1:0]    cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [IN_DATA_W-1:0]  in_data = '0;
  logic                  in_kind = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_DATA_W-1:0] out_data;
  logic                  out_found;
  logic                  out_last;

  int mismatches, backlog, words_seen;
  int gap_pct = 28;
  int wl_x = -10, wh_x = 10, wl_y = -10, wh_y = 10;
  int adds_sent, queries_sent, worlds_used;

  grid_nearest_occupied_search_unit #(
    .GRID_W(GRID_W), .GRID_H(GRID_H), .MAX_LIMIT(MAX_LIMIT)
  ) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .s_axis_tvalid_i(in_valid), .s_axis_tready_o(in_ready),
    .s_axis_tdata_i(in_data), .s_axis_tuser_i(in_kind),
    .m_axis_tvalid_o(out_valid), .m_axis_tready_i(out_ready),
    .m_axis_tdata_o(out_data), .m_axis_tuser_o(out_found), .m_axis_tlast_o(out_last)
  );

  gns_checker #(
    .GRID_W(GRID_W), .GRID_H(GRID_H), .MAX_LIMIT(MAX_LIMIT)
  ) checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .s_axis_tvalid_i(in_valid), .s_axis_tready_i(in_ready),
    .s_axis_tdata_i(in_data), .s_axis_tuser_i(in_kind),
    .m_axis_tvalid_i(out_valid), .m_axis_tready_i(out_ready),
    .m_axis_tdata_i(out_data), .m_axis_tuser_i(out_found), .m_axis_tlast_i(out_last),
    .mismatches_o(mismatches), .backlog_o(backlog), .words_seen_o(words_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side stalls at random.
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= gap_pct);
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #50ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Send one input word, with random idle cycles ahead of it; valid stays high afterwards.
  task automatic send_word(kind_e kind, int x, int y, int lim);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_data  <= {{(IN_DATA_W - LIM_W - 2*COORD_W){1'b0}}, lim[LIM_W-1:0],
                 y[COORD_W-1:0], x[COORD_W-1:0]};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (kind == KIND_ADD) adds_sent++;
    else queries_sent++;
  endtask

  // Hold off until every predicted word is back, then give an add time to land.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // Write all four bounds on consecutive cycles; only called while the block is idle.
  task automatic set_world(int lx, int hx, int ly, int hy);
    cfg_idx_e regs [4];
    int       vals [4];
    regs = '{CFG_MIN_X, CFG_MAX_X, CFG_MIN_Y, CFG_MAX_Y};
    vals = '{lx, hx, ly, hy};
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= regs[i];
      cfg_data <= vals[i][COORD_W-1:0];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    wl_x = lx;
    wh_x = (hx - lx >= GRID_W) ? lx + GRID_W - 1 : hx;
    wl_y = ly;
    wh_y = (hy - ly >= GRID_H) ? ly + GRID_H - 1 : hy;
    worlds_used++;
  endtask

  // Mostly inside the world, some just past an edge, some anywhere.
  function automatic int pick_coord(int lo, int hi);
    int r;
    r = $urandom_range(99);
    if (hi < lo || r < 10) return int'($urandom_range(1023)) - 512;
    if (r < 13) return lo - 1;
    if (r < 16) return hi + 1;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Small limits mostly, with zero and saturating values mixed in.
  function automatic int pick_limit();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 15) return 64 + int'($urandom_range(63));
    return 1 + int'($urandom_range(11));
  endfunction

  task automatic random_items(int n, int query_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < query_pct) begin
        send_word(KIND_QUERY, pick_coord(wl_x, wh_x), pick_coord(wl_y, wh_y), pick_limit());
      end else begin
        send_word(KIND_ADD, pick_coord(wl_x, wh_x), pick_coord(wl_y, wh_y),
                  int'($urandom_range(127)));
      end
    end
  endtask

  initial begin
    int w, lx, ly, wy;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default world: empty grid, corners, neighbors, overwrite, ignored adds.
    send_word(KIND_QUERY, 0, 0, 5);
    send_word(KIND_ADD, 0, 0, 0);
    send_word(KIND_ADD, -10, -10, 0);
    send_word(KIND_ADD, 10, 10, 0);
    send_word(KIND_ADD, -10, 10, 0);
    send_word(KIND_ADD, 10, -10, 0);
    send_word(KIND_ADD, 1, 0, 0);
    send_word(KIND_ADD, 0, 1, 0);
    send_word(KIND_ADD, -1, 0, 0);
    send_word(KIND_ADD, 0, -1, 127);
    send_word(KIND_ADD, 11, 0, 0);
    send_word(KIND_ADD, -512, 511, 0);
    send_word(KIND_ADD, 0, 0, 0);
    send_word(KIND_QUERY, 0, 0, 64);
    send_word(KIND_QUERY, 0, 0, 0);
    send_word(KIND_QUERY, 11, 0, 3);
    send_word(KIND_QUERY, 10, 10, 127);
    send_word(KIND_QUERY, 0, 0, 1);
    send_word(KIND_QUERY, -10, -10, 3);
    send_word(KIND_QUERY, 5, 5, 2);
    send_word(KIND_QUERY, 511, -512, 4);
    settle();

    // Widest world at the low corner; both axes get clipped to the grid.
    set_world(-512, 511, -512, 511);
    random_items(36, 0);
    send_word(KIND_QUERY, -512, -512, 64);
    send_word(KIND_QUERY, -449, -449, 8);
    send_word(KIND_QUERY, -480, -470, 3);
    send_word(KIND_QUERY, -448, -460, 5);
    settle();

    // Full grid at the high corner; old cells are read at their old offsets.
    set_world(448, 511, 448, 511);
    random_items(24, 0);
    send_word(KIND_ADD, 511, 511, 0);
    send_word(KIND_QUERY, 511, 511, 127);
    send_word(KIND_QUERY, 448, 448, 64);
    settle();

    // Inverted bounds on one axis, then the other: the world is empty.
    set_world(5, -5, -3, 3);
    random_items(6, 50);
    settle();
    set_world(-3, 3, 7, -7);
    random_items(4, 50);
    settle();

    // Small worlds at random places, one of them a single cell.
    for (int k = 0; k < 4; k++) begin
      if (k == 0) begin
        set_world(0, 0, 0, 0);
      end else begin
        w  = $urandom_range(15);
        wy = $urandom_range(15);
        lx = int'($urandom_range(1023 - w)) - 512;
        ly = int'($urandom_range(1023 - wy)) - 512;
        set_world(lx, lx + w, ly, ly + wy);
      end
      gap_pct = (k == 1) ? 0 : 28;
      if (k == 2) begin
        random_items(6, 45);
        settle();
        random_items(6, 45);
      end else begin
        random_items(12, 45);
      end
      settle();
    end
    gap_pct = 28;

    $display("Run covered %0d adds and %0d queries over %0d world settings,",
             adds_sent, queries_sent, worlds_used);
    $display("with %0d result words checked against the predicted nearest cells.", words_seen);
    if (mismatches == 0 && backlog == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> files.f
design/gns_pkg.sv
design/gns_ctrl.sv
design/gns_dp.sv
design/grid_nearest_occupied_search_unit.sv
test/gns_checker.sv
test/testbench.sv
